/* hw/rtl/dmu_pkg.sv */
// dmu_pkg: shared types, operation and space codes for the 8051 data memory unit
// used by the front, the back and the top level
`default_nettype none
package dmu_pkg;

  // default store sizes in bytes
  localparam int IRAM_BYTES_DEF = 256;
  localparam int XRAM_BYTES_DEF = 65536;
  localparam int PGM_BYTES_DEF  = 65536;
  localparam int SFR_BYTES      = 256;

  // operation codes
  localparam logic [3:0] OP_RD8      = 4'd0;
  localparam logic [3:0] OP_WR8      = 4'd1;
  localparam logic [3:0] OP_RD_DIR   = 4'd2;
  localparam logic [3:0] OP_WR_DIR   = 4'd3;
  localparam logic [3:0] OP_RD_BIT   = 4'd4;
  localparam logic [3:0] OP_WR_BIT   = 4'd5;
  localparam logic [3:0] OP_PUSH8    = 4'd6;
  localparam logic [3:0] OP_PUSH16   = 4'd7;
  localparam logic [3:0] OP_POP8     = 4'd8;
  localparam logic [3:0] OP_POP16    = 4'd9;
  localparam logic [3:0] OP_RD_DPTR  = 4'd10;
  localparam logic [3:0] OP_WR_DPTR  = 4'd11;
  localparam logic [3:0] OP_RD_PGM16 = 4'd12;

  // memory spaces
  localparam logic [1:0] SP_PGM = 2'd0;
  localparam logic [1:0] SP_INT = 2'd1;
  localparam logic [1:0] SP_SFR = 2'd2;
  localparam logic [1:0] SP_EXT = 2'd3;

  // special function register addresses
  localparam logic [16:0] SFR_SP  = 17'h00081;
  localparam logic [16:0] SFR_DPL = 17'h00082;
  localparam logic [16:0] SFR_DPH = 17'h00083;

  // classified operation, as held in the queue
  typedef struct packed {
    logic [3:0]  op;
    logic [1:0]  space;
    logic [15:0] addr;
    logic [15:0] data;
    logic [2:0]  bit_idx;
  } dmu_entry_t;

  // back status seen by the front
  typedef struct packed {
    logic clearing;
    logic busy;
  } dmu_bstat_t;

endpackage
`default_nettype wire

/* hw/rtl/dmu_if.sv */
// dmu_if: valid/ready channel interfaces for operations and results
// depends on nothing
`default_nettype none
interface dmu_in_if;
  logic        valid;
  logic        ready;
  logic [3:0]  opcode;
  logic [1:0]  space;
  logic [15:0] address;
  logic [15:0] data;
  modport source (output valid, input ready, output opcode, output space,
                  output address, output data);
  modport sink (input valid, output ready, input opcode, input space,
                input address, input data);
endinterface

interface dmu_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] read_data;
  logic        address_error;
  modport source (output valid, input ready, output read_data, output address_error);
  modport sink (input valid, output ready, input read_data, input address_error);
endinterface
`default_nettype wire

/* hw/rtl/mcu8051_data_memory_unit.sv */
// mcu8051_data_memory_unit: top level of the 8051 memory spaces block
// depends on dmu_pkg, dmu_if, dmu_front and dmu_back
//
// in_ch carries one operation per item (opcode, space, address, data);
// out_ch returns exactly one item per operation (read_data, address_error),
// in order. Both are valid/ready channels; an item moves when both are high.
// A front stage resolves the target space and byte address and places the
// operation in a two-entry queue; a back sequencer runs it over the four
// single-ported byte stores, one byte access per cycle unless out_ch is
// stalled, with registered reads. Each item is taken from the queue and run
// in byte access steps, kept one at a time by the single memory port of each
// store; the sequencer takes the next item only once it is done with the
// last one.
// After reset a clearing pass zeroes every store, one address per cycle
// from address 0 to max(XRAM_BYTES, PGM_BYTES) - 1 (65535 by default);
// in_ch.ready is low during it. When out_ch stalls, the finished result
// waits in the output register, the sequencer holds the next result, and
// the queue still takes up to two further items.
`default_nettype none
module mcu8051_data_memory_unit #(
  parameter int IRAM_BYTES = dmu_pkg::IRAM_BYTES_DEF,
  parameter int XRAM_BYTES = dmu_pkg::XRAM_BYTES_DEF,
  parameter int PGM_BYTES  = dmu_pkg::PGM_BYTES_DEF
) (
  input  wire        clk,
  input  wire        rst_n,
  dmu_in_if.sink     in_ch,
  dmu_out_if.source  out_ch
);

  logic                q_valid;
  logic                q_pop;
  dmu_pkg::dmu_entry_t q_head;
  dmu_pkg::dmu_bstat_t bstat;

  // front: accept and classify
  dmu_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .bstat   (bstat),
    .q_valid (q_valid),
    .q_head  (q_head),
    .q_pop   (q_pop)
  );

  // back: execute over the stores
  dmu_back #(
    .IRAM_BYTES (IRAM_BYTES),
    .XRAM_BYTES (XRAM_BYTES),
    .PGM_BYTES  (PGM_BYTES)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_head  (q_head),
    .q_pop   (q_pop),
    .bstat   (bstat),
    .out_ch  (out_ch)
  );

  // no item taken while the stores are being cleared
  a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
    bstat.clearing |-> !(in_ch.valid && in_ch.ready))
    else $error("item accepted during clearing pass");

  // sequencer stays idle while clearing
  a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
    bstat.clearing |-> !bstat.busy)
    else $error("sequencer busy during clearing pass");

  // a new result only follows sequencer work
  a_result_from_job: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_ch.valid) |-> $past(bstat.busy))
    else $error("result without an operation in progress");

endmodule
`default_nettype wire

/* hw/rtl/dmu_front.sv */
// dmu_front: accepts operations, resolves space and byte address, queues them
// depends on dmu_pkg and dmu_if
`default_nettype none
module dmu_front (
  input  wire                  clk,
  input  wire                  rst_n,
  dmu_in_if.sink               in_ch,
  input  dmu_pkg::dmu_bstat_t  bstat,
  output logic                 q_valid,
  output dmu_pkg::dmu_entry_t  q_head,
  input  wire                  q_pop
);

  dmu_pkg::dmu_entry_t q_mem_r [2];
  logic                wr_ptr_r, rd_ptr_r;
  logic [1:0]          count_r;
  dmu_pkg::dmu_entry_t cls;
  logic [7:0]          baddr;
  logic [7:0]          bbyte;
  logic                push;

  assign in_ch.ready = (count_r != 2'd2) && !bstat.clearing;
  assign push        = in_ch.valid && in_ch.ready;
  assign q_valid     = count_r != 2'd0;
  assign q_head      = q_mem_r[rd_ptr_r];

  // classify: pick the space and byte address of the operation
  always_comb begin
    baddr = in_ch.address[7:0];
    bbyte = baddr[7] ? (baddr & 8'hF8) : ((baddr >> 3) + 8'h20);
    cls.op      = in_ch.opcode;
    cls.space   = in_ch.space;
    cls.addr    = in_ch.address;
    cls.data    = in_ch.data;
    cls.bit_idx = baddr[2:0];
    case (in_ch.opcode)
      dmu_pkg::OP_RD_DIR, dmu_pkg::OP_WR_DIR: begin
        cls.space = (in_ch.address > 16'h007F) ? dmu_pkg::SP_SFR : dmu_pkg::SP_INT;
      end
      dmu_pkg::OP_RD_BIT, dmu_pkg::OP_WR_BIT: begin
        cls.space = bbyte[7] ? dmu_pkg::SP_SFR : dmu_pkg::SP_INT;
        cls.addr  = {8'h00, bbyte};
      end
      default: ;
    endcase
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) q_mem_r[wr_ptr_r] <= cls;
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (q_pop) rd_ptr_r <= !rd_ptr_r;
      if (push && !q_pop) count_r <= count_r + 2'd1;
      else if (!push && q_pop) count_r <= count_r - 2'd1;
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/dmu_back.sv */
// dmu_back: step sequencer over the four byte stores, with result register
// depends on dmu_pkg and dmu_if
`default_nettype none
module dmu_back #(
  parameter int IRAM_BYTES = dmu_pkg::IRAM_BYTES_DEF,
  parameter int XRAM_BYTES = dmu_pkg::XRAM_BYTES_DEF,
  parameter int PGM_BYTES  = dmu_pkg::PGM_BYTES_DEF
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  q_valid,
  input  dmu_pkg::dmu_entry_t  q_head,
  output logic                 q_pop,
  output dmu_pkg::dmu_bstat_t  bstat,
  dmu_out_if.source            out_ch
);

  localparam int IAW = $clog2(IRAM_BYTES);
  localparam int SAW = $clog2(dmu_pkg::SFR_BYTES);
  localparam int XAW = $clog2(XRAM_BYTES);
  localparam int PAW = $clog2(PGM_BYTES);
  localparam int CLR_DEPTH = (XRAM_BYTES > PGM_BYTES) ? XRAM_BYTES : PGM_BYTES;
  localparam logic [15:0] CLR_LAST = 16'(CLR_DEPTH - 1);
  localparam logic [16:0] IRAM_LIM = 17'(IRAM_BYTES);
  localparam logic [16:0] SFR_LIM  = 17'(dmu_pkg::SFR_BYTES);
  localparam logic [16:0] XRAM_LIM = 17'(XRAM_BYTES);
  localparam logic [16:0] PGM_LIM  = 17'(PGM_BYTES);

  logic [7:0] iram_mem [IRAM_BYTES];
  logic [7:0] sfr_mem  [dmu_pkg::SFR_BYTES];
  logic [7:0] xram_mem [XRAM_BYTES];
  logic [7:0] pgm_mem  [PGM_BYTES];

  logic                clr_r;
  logic [15:0]         clr_cnt_r;
  dmu_pkg::dmu_entry_t job_r;
  logic                busy_r;
  logic [1:0]          step_r;
  logic [7:0]          sp_r, sp_nxt;
  logic [15:0]         acc_r, acc_nxt;
  logic                err_r;
  logic                out_valid_r;
  logic [15:0]         out_data_r;
  logic                out_err_r;
  logic [7:0]          iram_q_r, sfr_q_r, xram_q_r, pgm_q_r;
  logic [1:0]          rsp_r;
  logic                oor_r;
  logic [7:0]          rd_byte;
  logic                a_en, a_we, last, in_range, go, out_full, cur_err;
  logic [1:0]          a_sp;
  logic [16:0]         a_addr;
  logic [7:0]          a_wd;
  logic                a_wr, a_rd;

  assign bstat.clearing = clr_r;
  assign bstat.busy     = busy_r;
  assign q_pop          = q_valid && !busy_r && !clr_r;
  assign out_ch.valid         = out_valid_r;
  assign out_ch.read_data     = out_data_r;
  assign out_ch.address_error = out_err_r;
  assign out_full = out_valid_r && !out_ch.ready;

  // registered read byte, zero when the address was out of range
  always_comb begin
    case (rsp_r)
      dmu_pkg::SP_PGM: rd_byte = pgm_q_r;
      dmu_pkg::SP_INT: rd_byte = iram_q_r;
      dmu_pkg::SP_SFR: rd_byte = sfr_q_r;
      default:         rd_byte = xram_q_r;
    endcase
    if (oor_r) rd_byte = 8'h00;
  end

  // step decode per operation
  always_comb begin
    a_en    = 1'b0;
    a_we    = 1'b0;
    a_sp    = job_r.space;
    a_addr  = {1'b0, job_r.addr};
    a_wd    = job_r.data[7:0];
    last    = 1'b0;
    sp_nxt  = sp_r;
    acc_nxt = acc_r;
    case (job_r.op)
      dmu_pkg::OP_RD8, dmu_pkg::OP_RD_DIR: begin
        if (step_r == 2'd0) a_en = 1'b1;
        else begin
          last = 1'b1;
          acc_nxt = {8'h00, rd_byte};
        end
      end
      dmu_pkg::OP_WR8, dmu_pkg::OP_WR_DIR: begin
        a_en = 1'b1;
        a_we = 1'b1;
        last = 1'b1;
      end
      dmu_pkg::OP_RD_BIT: begin
        if (step_r == 2'd0) a_en = 1'b1;
        else begin
          last = 1'b1;
          acc_nxt = {15'h0000, rd_byte[job_r.bit_idx]};
        end
      end
      dmu_pkg::OP_WR_BIT: begin
        a_en = 1'b1;
        if (step_r != 2'd0) begin
          a_we = 1'b1;
          last = 1'b1;
          a_wd = rd_byte;
          a_wd[job_r.bit_idx] = job_r.data[0];
        end
      end
      dmu_pkg::OP_PUSH8, dmu_pkg::OP_PUSH16: begin
        a_en = 1'b1;
        case (step_r)
          2'd0: begin
            a_sp = dmu_pkg::SP_SFR;
            a_addr = dmu_pkg::SFR_SP;
          end
          2'd1: begin
            a_we = 1'b1;
            sp_nxt = rd_byte + 8'd1;
            a_sp = dmu_pkg::SP_INT;
            a_addr = {9'h000, sp_nxt};
          end
          default: begin
            a_we = 1'b1;
            if (job_r.op == dmu_pkg::OP_PUSH16 && step_r == 2'd2) begin
              sp_nxt = sp_r + 8'd1;
              a_sp = dmu_pkg::SP_INT;
              a_addr = {9'h000, sp_nxt};
              a_wd = job_r.data[15:8];
            end else begin
              last = 1'b1;
              a_sp = dmu_pkg::SP_SFR;
              a_addr = dmu_pkg::SFR_SP;
              a_wd = sp_r;
            end
          end
        endcase
      end
      dmu_pkg::OP_POP8, dmu_pkg::OP_POP16: begin
        a_en = 1'b1;
        case (step_r)
          2'd0: begin
            a_sp = dmu_pkg::SP_SFR;
            a_addr = dmu_pkg::SFR_SP;
          end
          2'd1: begin
            sp_nxt = rd_byte - 8'd1;
            a_sp = dmu_pkg::SP_INT;
            a_addr = {9'h000, rd_byte};
          end
          default: begin
            if (job_r.op == dmu_pkg::OP_POP16 && step_r == 2'd2) begin
              acc_nxt = {rd_byte, 8'h00};
              sp_nxt = sp_r - 8'd1;
              a_sp = dmu_pkg::SP_INT;
              a_addr = {9'h000, sp_r};
            end else begin
              a_we = 1'b1;
              last = 1'b1;
              acc_nxt = {acc_r[15:8], rd_byte};
              a_sp = dmu_pkg::SP_SFR;
              a_addr = dmu_pkg::SFR_SP;
              a_wd = sp_r;
            end
          end
        endcase
      end
      dmu_pkg::OP_RD_DPTR: begin
        a_sp = dmu_pkg::SP_SFR;
        case (step_r)
          2'd0: begin
            a_en = 1'b1;
            a_addr = dmu_pkg::SFR_DPH;
          end
          2'd1: begin
            a_en = 1'b1;
            a_addr = dmu_pkg::SFR_DPL;
            acc_nxt = {rd_byte, 8'h00};
          end
          default: begin
            last = 1'b1;
            acc_nxt = {acc_r[15:8], rd_byte};
          end
        endcase
      end
      dmu_pkg::OP_WR_DPTR: begin
        a_en = 1'b1;
        a_we = 1'b1;
        a_sp = dmu_pkg::SP_SFR;
        if (step_r == 2'd0) begin
          a_addr = dmu_pkg::SFR_DPH;
          a_wd = job_r.data[15:8];
        end else begin
          a_addr = dmu_pkg::SFR_DPL;
          last = 1'b1;
        end
      end
      dmu_pkg::OP_RD_PGM16: begin
        a_sp = dmu_pkg::SP_PGM;
        case (step_r)
          2'd0: a_en = 1'b1;
          2'd1: begin
            a_en = 1'b1;
            a_addr = {1'b0, job_r.addr} + 17'd1;
            acc_nxt = {rd_byte, 8'h00};
          end
          default: begin
            last = 1'b1;
            acc_nxt = {acc_r[15:8], rd_byte};
          end
        endcase
      end
      default: last = 1'b1;
    endcase
  end

  // range check and gating
  always_comb begin
    case (a_sp)
      dmu_pkg::SP_PGM: in_range = a_addr < PGM_LIM;
      dmu_pkg::SP_INT: in_range = a_addr < IRAM_LIM;
      dmu_pkg::SP_SFR: in_range = a_addr < SFR_LIM;
      default:         in_range = a_addr < XRAM_LIM;
    endcase
    go      = busy_r && !(last && out_full);
    cur_err = go && a_en && !in_range;
    a_wr    = go && a_en && a_we && in_range;
    a_rd    = go && a_en && !a_we;
  end

  // internal ram
  always_ff @(posedge clk) begin
    if (clr_r) iram_mem[clr_cnt_r[IAW-1:0]] <= 8'h00;
    else if (a_wr && a_sp == dmu_pkg::SP_INT) iram_mem[a_addr[IAW-1:0]] <= a_wd;
    if (a_rd && a_sp == dmu_pkg::SP_INT) iram_q_r <= iram_mem[a_addr[IAW-1:0]];
  end

  // special function registers
  always_ff @(posedge clk) begin
    if (clr_r) sfr_mem[clr_cnt_r[SAW-1:0]] <= 8'h00;
    else if (a_wr && a_sp == dmu_pkg::SP_SFR) sfr_mem[a_addr[SAW-1:0]] <= a_wd;
    if (a_rd && a_sp == dmu_pkg::SP_SFR) sfr_q_r <= sfr_mem[a_addr[SAW-1:0]];
  end

  // external ram
  always_ff @(posedge clk) begin
    if (clr_r) xram_mem[clr_cnt_r[XAW-1:0]] <= 8'h00;
    else if (a_wr && a_sp == dmu_pkg::SP_EXT) xram_mem[a_addr[XAW-1:0]] <= a_wd;
    if (a_rd && a_sp == dmu_pkg::SP_EXT) xram_q_r <= xram_mem[a_addr[XAW-1:0]];
  end

  // program store
  always_ff @(posedge clk) begin
    if (clr_r) pgm_mem[clr_cnt_r[PAW-1:0]] <= 8'h00;
    else if (a_wr && a_sp == dmu_pkg::SP_PGM) pgm_mem[a_addr[PAW-1:0]] <= a_wd;
    if (a_rd && a_sp == dmu_pkg::SP_PGM) pgm_q_r <= pgm_mem[a_addr[PAW-1:0]];
  end

  // read tag, job payload and result data
  always_ff @(posedge clk) begin
    if (a_rd) begin
      rsp_r <= a_sp;
      oor_r <= !in_range;
    end
    if (q_pop) job_r <= q_head;
    if (go && last) begin
      out_data_r <= acc_nxt;
      out_err_r  <= err_r | cur_err;
    end
  end

  // clearing pass and sequencer control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r       <= 1'b1;
      clr_cnt_r   <= 16'h0000;
      busy_r      <= 1'b0;
      step_r      <= 2'd0;
      sp_r        <= 8'h00;
      acc_r       <= 16'h0000;
      err_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (clr_r) begin
        clr_cnt_r <= clr_cnt_r + 16'd1;
        if (clr_cnt_r == CLR_LAST) clr_r <= 1'b0;
      end
      if (out_valid_r && out_ch.ready) out_valid_r <= 1'b0;
      if (q_pop) begin
        busy_r <= 1'b1;
        step_r <= 2'd0;
        acc_r  <= 16'h0000;
        err_r  <= 1'b0;
      end else if (go) begin
        if (last) begin
          busy_r      <= 1'b0;
          out_valid_r <= 1'b1;
        end else begin
          step_r <= step_r + 2'd1;
          sp_r   <= sp_nxt;
          acc_r  <= acc_nxt;
          err_r  <= err_r | cur_err;
        end
      end
    end
  end

endmodule
`default_nettype wire

/* sim/tb_mcu8051_data_memory_unit.sv */
// tb_mcu8051_data_memory_unit: self-checking bench for the 8051 data memory unit
// depends on dmu_pkg, dmu_if and the mcu8051_data_memory_unit top level
// directed and random operations with random idling, checked against a local memory predictor
`default_nettype none
module tb_mcu8051_data_memory_unit;

  typedef struct packed {
    logic [3:0]  opcode;
    logic [1:0]  space;
    logic [15:0] address;
    logic [15:0] data;
  } mem_op_t;

  typedef struct packed {
    logic [15:0] read_data;
    logic        address_error;
  } mem_rsp_t;

  localparam int LIMIT_CYCLES = 400000;

  logic clk;
  logic rst_n;
  dmu_in_if  in_ch ();
  dmu_out_if out_ch ();

  mcu8051_data_memory_unit dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch.sink),
    .out_ch(out_ch.source)
  );

  // predictor copy of the four stores
  logic [7:0] iram_m [256];
  logic [7:0] sfr_m  [256];
  logic [7:0] xram_m [65536];
  logic [7:0] pgm_m  [65536];

  mem_op_t  pending_ops[$];
  mem_rsp_t expected_rsps[$];
  int       mismatches;
  bit       stim_done;
  int       cycle_cnt;
  int       hold_cnt;
  int       rx_wait;
  int       tx_wait;

  // byte read with range check
  function automatic logic [7:0] mem_rd(logic [1:0] sp, int addr, ref bit err);
    int lim;
    lim = (sp == dmu_pkg::SP_INT || sp == dmu_pkg::SP_SFR) ? 256 : 65536;
    if (addr >= lim) begin
      err = 1;
      return 8'h00;
    end
    case (sp)
      dmu_pkg::SP_PGM: return pgm_m[addr];
      dmu_pkg::SP_INT: return iram_m[addr];
      dmu_pkg::SP_SFR: return sfr_m[addr];
      default: return xram_m[addr];
    endcase
  endfunction

  // byte write with range check
  function automatic void mem_wr(logic [1:0] sp, int addr, logic [7:0] v, ref bit err);
    int lim;
    lim = (sp == dmu_pkg::SP_INT || sp == dmu_pkg::SP_SFR) ? 256 : 65536;
    if (addr >= lim) begin
      err = 1;
      return;
    end
    case (sp)
      dmu_pkg::SP_PGM: pgm_m[addr] = v;
      dmu_pkg::SP_INT: iram_m[addr] = v;
      dmu_pkg::SP_SFR: sfr_m[addr] = v;
      default: xram_m[addr] = v;
    endcase
  endfunction

  function automatic logic [1:0] direct_sp(int addr);
    return (addr > 'h7F) ? dmu_pkg::SP_SFR : dmu_pkg::SP_INT;
  endfunction

  // expected result of one operation, updating the store copies
  function automatic mem_rsp_t predict_access(mem_op_t op);
    bit err;
    logic [15:0] rd;
    logic [7:0] stk, v;
    int byte_a, bit_i;
    err = 0;
    rd = 0;
    byte_a = (op.address[7:0] > 8'h7F) ? int'(op.address[7:0] & 8'hF8)
                                       : (int'(op.address[7:3]) + 'h20);
    bit_i = int'(op.address[2:0]);
    case (op.opcode)
      dmu_pkg::OP_RD8: rd = 16'(mem_rd(op.space, op.address, err));
      dmu_pkg::OP_WR8: mem_wr(op.space, op.address, op.data[7:0], err);
      dmu_pkg::OP_RD_DIR: rd = 16'(mem_rd(direct_sp(op.address), op.address, err));
      dmu_pkg::OP_WR_DIR: mem_wr(direct_sp(op.address), op.address, op.data[7:0], err);
      dmu_pkg::OP_RD_BIT: begin
        v = mem_rd(direct_sp(byte_a), byte_a, err);
        rd = 16'(v[bit_i]);
      end
      dmu_pkg::OP_WR_BIT: begin
        v = mem_rd(direct_sp(byte_a), byte_a, err);
        v[bit_i] = op.data[0];
        mem_wr(direct_sp(byte_a), byte_a, v, err);
      end
      dmu_pkg::OP_PUSH8: begin
        stk = mem_rd(dmu_pkg::SP_SFR, dmu_pkg::SFR_SP, err) + 8'd1;
        mem_wr(dmu_pkg::SP_INT, stk, op.data[7:0], err);
        mem_wr(dmu_pkg::SP_SFR, dmu_pkg::SFR_SP, stk, err);
      end
      dmu_pkg::OP_PUSH16: begin
        stk = mem_rd(dmu_pkg::SP_SFR, dmu_pkg::SFR_SP, err) + 8'd1;
        mem_wr(dmu_pkg::SP_INT, stk, op.data[7:0], err);
        stk = stk + 8'd1;
        mem_wr(dmu_pkg::SP_INT, stk, op.data[15:8], err);
        mem_wr(dmu_pkg::SP_SFR, dmu_pkg::SFR_SP, stk, err);
      end
      dmu_pkg::OP_POP8: begin
        stk = mem_rd(dmu_pkg::SP_SFR, dmu_pkg::SFR_SP, err);
        rd = 16'(mem_rd(dmu_pkg::SP_INT, stk, err));
        mem_wr(dmu_pkg::SP_SFR, dmu_pkg::SFR_SP, stk - 8'd1, err);
      end
      dmu_pkg::OP_POP16: begin
        stk = mem_rd(dmu_pkg::SP_SFR, dmu_pkg::SFR_SP, err);
        rd[15:8] = mem_rd(dmu_pkg::SP_INT, stk, err);
        stk = stk - 8'd1;
        rd[7:0] = mem_rd(dmu_pkg::SP_INT, stk, err);
        mem_wr(dmu_pkg::SP_SFR, dmu_pkg::SFR_SP, stk - 8'd1, err);
      end
      dmu_pkg::OP_RD_DPTR: begin
        rd[15:8] = mem_rd(dmu_pkg::SP_SFR, dmu_pkg::SFR_DPH, err);
        rd[7:0] = mem_rd(dmu_pkg::SP_SFR, dmu_pkg::SFR_DPL, err);
      end
      dmu_pkg::OP_WR_DPTR: begin
        mem_wr(dmu_pkg::SP_SFR, dmu_pkg::SFR_DPH, op.data[15:8], err);
        mem_wr(dmu_pkg::SP_SFR, dmu_pkg::SFR_DPL, op.data[7:0], err);
      end
      dmu_pkg::OP_RD_PGM16: begin
        rd[15:8] = mem_rd(dmu_pkg::SP_PGM, op.address, err);
        rd[7:0] = mem_rd(dmu_pkg::SP_PGM, int'(op.address) + 1, err);
      end
      default: ;
    endcase
    return '{read_data: rd, address_error: err};
  endfunction

  function automatic mem_op_t mk_op(logic [3:0] oc, logic [1:0] sp, logic [15:0] a,
                                    logic [15:0] d);
    return '{opcode: oc, space: sp, address: a, data: d};
  endfunction

  // random address, mostly in the small ranges where state is shared
  function automatic logic [15:0] rand_addr();
    case ($urandom_range(0, 9))
      0, 1: return 16'($urandom_range(0, 65535));
      2: return 16'(32'hFFFF - $urandom_range(0, 2));
      3: return 16'($urandom_range(256, 300));
      default: return 16'($urandom_range(0, 255));
    endcase
  endfunction

  // clock
  initial clk = 0;
  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  // stimulus
  initial begin
    mem_op_t op;
    int n;
    rst_n = 0;
    stim_done = 0;
    for (int i = 0; i < 256; i++) begin
      iram_m[i] = 0;
      sfr_m[i] = 0;
    end
    for (int i = 0; i < 65536; i++) begin
      xram_m[i] = 0;
      pgm_m[i] = 0;
    end
    // directed part
    pending_ops.push_back(mk_op(dmu_pkg::OP_WR8, dmu_pkg::SP_PGM, 16'hFFFF, 16'h00A5));
    pending_ops.push_back(mk_op(dmu_pkg::OP_WR8, dmu_pkg::SP_PGM, 16'h0000, 16'hFF3C));
    pending_ops.push_back(mk_op(dmu_pkg::OP_RD_PGM16, dmu_pkg::SP_PGM, 16'hFFFF, 16'h0000));
    pending_ops.push_back(mk_op(dmu_pkg::OP_RD_PGM16, dmu_pkg::SP_PGM, 16'hFFFE, 16'hFFFF));
    pending_ops.push_back(mk_op(dmu_pkg::OP_WR8, dmu_pkg::SP_EXT, 16'hFFFF, 16'h5A5A));
    pending_ops.push_back(mk_op(dmu_pkg::OP_RD8, dmu_pkg::SP_EXT, 16'hFFFF, 16'h0000));
    pending_ops.push_back(mk_op(dmu_pkg::OP_WR8, dmu_pkg::SP_INT, 16'h0100, 16'h0011));
    pending_ops.push_back(mk_op(dmu_pkg::OP_RD8, dmu_pkg::SP_SFR, 16'hFFFF, 16'h0000));
    pending_ops.push_back(mk_op(dmu_pkg::OP_WR_DIR, dmu_pkg::SP_PGM, 16'h007F, 16'h00C3));
    pending_ops.push_back(mk_op(dmu_pkg::OP_WR_DIR, dmu_pkg::SP_PGM, 16'h0080, 16'h0077));
    pending_ops.push_back(mk_op(dmu_pkg::OP_RD_DIR, dmu_pkg::SP_PGM, 16'h0180, 16'h0000));
    pending_ops.push_back(mk_op(dmu_pkg::OP_WR_BIT, dmu_pkg::SP_PGM, 16'hFF07, 16'hFFFF));
    pending_ops.push_back(mk_op(dmu_pkg::OP_WR_BIT, dmu_pkg::SP_PGM, 16'h0085, 16'h0001));
    pending_ops.push_back(mk_op(dmu_pkg::OP_RD_BIT, dmu_pkg::SP_PGM, 16'h0007, 16'h0000));
    pending_ops.push_back(mk_op(dmu_pkg::OP_RD_BIT, dmu_pkg::SP_PGM, 16'h0085, 16'h0000));
    pending_ops.push_back(mk_op(dmu_pkg::OP_WR_DIR, dmu_pkg::SP_PGM, 16'h0081, 16'h00FF));
    pending_ops.push_back(mk_op(dmu_pkg::OP_PUSH8, dmu_pkg::SP_PGM, 16'h0000, 16'h00EE));
    pending_ops.push_back(mk_op(dmu_pkg::OP_PUSH16, dmu_pkg::SP_PGM, 16'h0000, 16'hBEEF));
    pending_ops.push_back(mk_op(dmu_pkg::OP_POP16, dmu_pkg::SP_PGM, 16'h0000, 16'h0000));
    pending_ops.push_back(mk_op(dmu_pkg::OP_POP8, dmu_pkg::SP_PGM, 16'h0000, 16'h0000));
    pending_ops.push_back(mk_op(dmu_pkg::OP_POP8, dmu_pkg::SP_PGM, 16'h0000, 16'h0000));
    pending_ops.push_back(mk_op(dmu_pkg::OP_WR_DPTR, dmu_pkg::SP_PGM, 16'h0000, 16'hFFFF));
    pending_ops.push_back(mk_op(dmu_pkg::OP_RD_DPTR, dmu_pkg::SP_PGM, 16'h0000, 16'h0000));
    pending_ops.push_back(mk_op(4'd13, dmu_pkg::SP_EXT, 16'hFFFF, 16'hFFFF));
    pending_ops.push_back(mk_op(4'd15, dmu_pkg::SP_PGM, 16'h0000, 16'h0000));
    // random part: mostly valid ops, stack runs of pushes and pops
    n = 0;
    while (n < 630) begin
      if ($urandom_range(0, 5) == 0) begin
        repeat ($urandom_range(2, 6)) begin
          pending_ops.push_back(mk_op($urandom_range(0, 1) ? dmu_pkg::OP_PUSH16
                                                           : dmu_pkg::OP_PUSH8,
                                      2'($urandom), 16'($urandom), 16'($urandom)));
          n++;
        end
        repeat ($urandom_range(2, 6)) begin
          pending_ops.push_back(mk_op($urandom_range(0, 1) ? dmu_pkg::OP_POP16
                                                           : dmu_pkg::OP_POP8,
                                      2'($urandom), 16'($urandom), 16'($urandom)));
          n++;
        end
      end else begin
        op.opcode = ($urandom_range(0, 30) == 0) ? 4'($urandom_range(13, 15))
                                                 : 4'($urandom_range(0, 12));
        op.space = 2'($urandom);
        op.address = rand_addr();
        op.data = 16'($urandom);
        pending_ops.push_back(op);
        n++;
      end
    end
    repeat (11) @(posedge clk);
    rst_n <= 1;
    stim_done = 1;
  end

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 0;
      in_ch.opcode <= 0;
      in_ch.space <= 0;
      in_ch.address <= 0;
      in_ch.data <= 0;
      tx_wait <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        expected_rsps.push_back(predict_access(mem_op_t'({in_ch.opcode, in_ch.space,
                                                          in_ch.address, in_ch.data})));
      end
      if (in_ch.valid && !in_ch.ready) begin
        // hold the offered item
      end else if (tx_wait > 0) begin
        in_ch.valid <= 0;
        tx_wait <= tx_wait - 1;
      end else if (pending_ops.size() > 0) begin
        mem_op_t op;
        op = pending_ops.pop_front();
        in_ch.valid <= 1;
        in_ch.opcode <= op.opcode;
        in_ch.space <= op.space;
        in_ch.address <= op.address;
        in_ch.data <= op.data;
        tx_wait <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 9) : 0;
      end else begin
        in_ch.valid <= 0;
      end
    end
  end

  // receiver, with one long hold-off partway through
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 0;
      rx_wait <= 0;
      hold_cnt <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        mem_rsp_t want;
        if (expected_rsps.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: read_data=%h err=%b",
                     out_ch.read_data, out_ch.address_error);
        end else begin
          want = expected_rsps.pop_front();
          if (want.read_data !== out_ch.read_data
              || want.address_error !== out_ch.address_error) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected %h/%b got %h/%b", want.read_data,
                       want.address_error, out_ch.read_data, out_ch.address_error);
          end
        end
      end
      if (cycle_cnt > 66000 && hold_cnt < 200) begin
        hold_cnt <= hold_cnt + 1;
        out_ch.ready <= 0;
      end else if (rx_wait > 0) begin
        rx_wait <= rx_wait - 1;
        out_ch.ready <= 0;
      end else if (out_ch.valid && out_ch.ready) begin
        rx_wait <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 9) : 0;
        out_ch.ready <= 0;
      end else begin
        out_ch.ready <= 1;
      end
    end
  end

  // end of run and timeout
  initial begin
    cycle_cnt = 0;
    mismatches = 0;
    wait (stim_done);
    while (cycle_cnt < LIMIT_CYCLES && (pending_ops.size() > 0 || in_ch.valid
           || expected_rsps.size() > 0)) begin
      @(posedge clk);
      cycle_cnt++;
    end
    if (cycle_cnt >= LIMIT_CYCLES) begin
      $display("[mcu8051_data_memory_unit] ERROR");
    end else begin
      repeat (20) @(posedge clk);
      if (mismatches == 0 && expected_rsps.size() == 0)
        $display("[mcu8051_data_memory_unit] OK");
      else
        $display("[mcu8051_data_memory_unit] ERROR");
    end
    $finish;
  end
endmodule
`default_nettype wire
